// ----- hdl/gcd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types, constants and weight table for the grid cell deformation block.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int MaxColumns = 1024;
  localparam int ColBits    = 10;
  localparam int DispBits   = 32;
  localparam int SumBits    = 36;
  localparam int MagBits    = 35;
  localparam int OutBits    = 40;
  localparam int AccBits    = 82;
  localparam int RootBits   = 41;

  localparam logic [39:0] Cap40 = 40'hFF_FFFF_FFFF;
  localparam logic [39:0] Pos39 = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] Neg39 = 40'h80_0000_0000;

  localparam logic [1:0] RegColumns = 2'd0;
  localparam logic [1:0] RegShear   = 2'd1;
  localparam logic [1:0] RegTwist   = 2'd2;
  localparam logic [1:0] RegAffine  = 2'd3;

  // Weight patterns: rows are terms, columns are the eight cell values.
  localparam logic signed [1:0] Weight [6][8] = '{
    '{-2'sd1, -2'sd1,  2'sd1, -2'sd1, -2'sd1,  2'sd1,  2'sd1,  2'sd1},
    '{ 2'sd1, -2'sd1,  2'sd1,  2'sd1, -2'sd1, -2'sd1, -2'sd1,  2'sd1},
    '{ 2'sd0, -2'sd1,  2'sd0,  2'sd1,  2'sd0,  2'sd1,  2'sd0, -2'sd1},
    '{-2'sd1,  2'sd0,  2'sd1,  2'sd0,  2'sd1,  2'sd0, -2'sd1,  2'sd0},
    '{-2'sd1,  2'sd1,  2'sd1,  2'sd1, -2'sd1, -2'sd1,  2'sd1, -2'sd1},
    '{-2'sd1, -2'sd1, -2'sd1,  2'sd1,  2'sd1, -2'sd1,  2'sd1,  2'sd1}
  };

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CHECK, S_MUL_LO, S_MUL_HI, S_SQUARE,
    S_SH_INIT, S_SH_RUN, S_AL_INIT, S_AL_RUN, S_OUT
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       close_cell;
    logic       acc_clr;
    logic       mul_lo;
    logic       mul_hi;
    logic       sq_step;
    logic       sh_save;
    logic       root_init;
    logic       root_sel;
    logic       root_step;
    logic       shear_save;
    logic       out_load;
    logic [2:0] term;
    logic [1:0] part;
    logic [1:0] sqk;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic miss;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/gcd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_ctrl
// Sequencer: steps one node through read, sums, scaling, squares and roots.
// ----------------------------------------------------------------------------
module gcd_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  gcd_pkg::sts_t    sts,
  output gcd_pkg::cmd_t    cmd
);
  import gcd_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] term_r, term_nxt;
  logic [1:0] part_r, part_nxt;
  logic [1:0] sqk_r, sqk_nxt;
  logic [5:0] iter_r, iter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      term_r  <= '0;
      part_r  <= '0;
      sqk_r   <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
      part_r  <= part_nxt;
      sqk_r   <= sqk_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    part_nxt  = part_r;
    sqk_nxt   = sqk_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    cmd.term  = term_r;
    cmd.part  = part_r;
    cmd.sqk   = sqk_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
        if (in_tvalid) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.close_cell = 1'b1;
        state_nxt      = S_CHECK;
      end
      S_CHECK: begin
        cmd.acc_clr = 1'b1;
        term_nxt    = '0;
        part_nxt    = '0;
        sqk_nxt     = '0;
        if (!sts.emit) state_nxt = S_IDLE;
        else if (sts.miss) state_nxt = S_OUT;
        else state_nxt = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        term_nxt   = term_r + 3'd1;
        state_nxt  = (term_r == 3'd5) ? S_SQUARE : S_MUL_LO;
      end
      S_SQUARE: begin
        cmd.sq_step = 1'b1;
        if (part_r == 2'd2) begin
          part_nxt = '0;
          sqk_nxt  = sqk_r + 2'd1;
          if (sqk_r == 2'd1) cmd.sh_save = 1'b1;
          if (sqk_r == 2'd3) state_nxt = S_SH_INIT;
        end else begin
          part_nxt = part_r + 2'd1;
        end
      end
      S_SH_INIT: begin
        cmd.root_init = 1'b1;
        cmd.root_sel  = 1'b0;
        iter_nxt      = '0;
        state_nxt     = S_SH_RUN;
      end
      S_SH_RUN: begin
        cmd.root_step = 1'b1;
        iter_nxt      = iter_r + 6'd1;
        if (iter_r == 6'(RootBits - 1)) state_nxt = S_AL_INIT;
      end
      S_AL_INIT: begin
        cmd.shear_save = 1'b1;
        cmd.root_init  = 1'b1;
        cmd.root_sel   = 1'b1;
        iter_nxt       = '0;
        state_nxt      = S_AL_RUN;
      end
      S_AL_RUN: begin
        cmd.root_step = 1'b1;
        iter_nxt      = iter_r + 6'd1;
        if (iter_r == 6'(RootBits - 1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/gcd_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_dpath
// Line buffer, cell sums, gain scaling, square accumulation, bit-serial root
// and the output register.
// ----------------------------------------------------------------------------
module gcd_dpath (
  input  wire              clk,
  input  wire              rst_n,
  input  gcd_pkg::cmd_t    cmd,
  output gcd_pkg::sts_t    sts,
  input  wire  [63:0]      in_tdata,
  input  wire  [1:0]       in_tuser,
  input  wire              cfg_we,
  input  wire  [1:0]       cfg_index,
  input  wire  [31:0]      cfg_data,
  output logic             out_tvalid,
  input  wire              out_tready,
  output logic [159:0]     out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);
  import gcd_pkg::*;

  // configuration
  logic [10:0] cols_cfg_r;
  logic [31:0] shear_gain_r, twist_gain_r, affine_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r    <= 11'd1024;
      shear_gain_r  <= 32'd65536;
      twist_gain_r  <= 32'd65536;
      affine_gain_r <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        RegColumns: cols_cfg_r    <= cfg_data[10:0];
        RegShear:   shear_gain_r  <= cfg_data;
        RegTwist:   twist_gain_r  <= cfg_data;
        RegAffine:  affine_gain_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  logic [10:0] cols;
  always_comb begin
    if (cols_cfg_r < 11'd2) cols = 11'd2;
    else if (cols_cfg_r > 11'(MaxColumns)) cols = 11'(MaxColumns);
    else cols = cols_cfg_r;
  end

  // node state and line buffer
  logic [64:0]        lb_mem [MaxColumns];
  logic [64:0]        lb_rd_r;
  logic [64:0]        cur_r, left_r, ul_r;
  logic [ColBits-1:0] index_r, col_r, col_sel;
  logic               past_r;
  logic               emit_r, miss_r, last_r;

  assign col_sel = in_tuser[1] ? '0 : index_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) lb_rd_r <= lb_mem[col_sel];
    if (cmd.close_cell) lb_mem[col_r] <= cur_r;
  end

  logic last_c;
  assign last_c = {1'b0, col_r} >= (cols - 11'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0;
      past_r  <= 1'b0;
      left_r  <= '0;
      ul_r    <= '0;
      emit_r  <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        col_r <= col_sel;
        cur_r <= {in_tuser[0], in_tdata};
        if (in_tuser[1]) begin
          index_r <= '0;
          past_r  <= 1'b0;
        end
      end
      if (cmd.close_cell) begin
        emit_r <= past_r && (col_r != '0);
        miss_r <= left_r[64] | cur_r[64] | ul_r[64] | lb_rd_r[64];
        last_r <= last_c;
        ul_r   <= lb_rd_r;
        left_r <= cur_r;
        if (last_c) begin
          index_r <= '0;
          past_r  <= 1'b1;
        end else begin
          index_r <= col_r + 1'b1;
        end
      end
    end
  end

  // cell sums
  logic signed [SumBits-1:0] vals [8];
  logic [MagBits-1:0]        mag_r [6];
  logic [5:0]                neg_r;

  always_comb begin
    vals[0] = SumBits'($signed(left_r[31:0]));
    vals[1] = SumBits'($signed(left_r[63:32]));
    vals[2] = SumBits'($signed(cur_r[31:0]));
    vals[3] = SumBits'($signed(cur_r[63:32]));
    vals[4] = SumBits'($signed(ul_r[31:0]));
    vals[5] = SumBits'($signed(ul_r[63:32]));
    vals[6] = SumBits'($signed(lb_rd_r[31:0]));
    vals[7] = SumBits'($signed(lb_rd_r[63:32]));
  end

  always_ff @(posedge clk) begin
    logic signed [SumBits-1:0] s;
    logic signed [SumBits-1:0] a;
    if (cmd.close_cell) begin
      for (int t = 0; t < 6; t++) begin
        s = '0;
        for (int j = 0; j < 8; j++) begin
          if (Weight[t][j] == 2'sd1) s = s + vals[j];
          else if (Weight[t][j] == -2'sd1) s = s - vals[j];
        end
        a = s[SumBits-1] ? -s : s;
        mag_r[t] <= a[MagBits-1:0];
        neg_r[t] <= s[SumBits-1];
      end
    end
  end

  // gain scaling, a low and a high product step per term
  logic [31:0]        gain;
  logic [MagBits-1:0] mag_sel;
  logic [63:0]        prod_r;
  logic [34:0]        prod_hi;
  logic [67:0]        full;
  logic [51:0]        quot;
  logic [39:0]        scaled_r [6];

  always_comb begin
    if (cmd.term < 3'd2) gain = shear_gain_r;
    else if (cmd.term < 3'd4) gain = twist_gain_r;
    else gain = affine_gain_r;
    mag_sel = mag_r[cmd.term];
    prod_hi = 35'(mag_sel[34:32]) * 35'(gain);
    full    = 68'(prod_r) + (68'(prod_hi) << 32) + 68'h8000;
    quot    = full[67:16];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) prod_r <= 64'(mag_sel[31:0]) * 64'(gain);
    if (cmd.mul_hi) scaled_r[cmd.term] <= (quot > 52'(Cap40)) ? Cap40 : quot[39:0];
  end

  // square accumulation, three partial products per term
  logic [19:0]        sq_h, sq_l, op_a, op_b;
  logic [39:0]        sq_p;
  logic [AccBits-1:0] sq_add, acc_r, acc_nxt, sh_r;

  always_comb begin
    sq_h = scaled_r[cmd.sqk][39:20];
    sq_l = scaled_r[cmd.sqk][19:0];
    op_a = (cmd.part == 2'd2) ? sq_h : sq_l;
    op_b = (cmd.part == 2'd0) ? sq_l : sq_h;
    sq_p = 40'(op_a) * 40'(op_b);
    case (cmd.part)
      2'd0:    sq_add = AccBits'(sq_p);
      2'd1:    sq_add = AccBits'(sq_p) << 21;
      default: sq_add = AccBits'(sq_p) << 40;
    endcase
    acc_nxt = acc_r + sq_add;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) acc_r <= '0;
    else if (cmd.sq_step) acc_r <= acc_nxt;
    if (cmd.sh_save) sh_r <= acc_nxt;
  end

  // restoring square root, one result bit per cycle
  logic [AccBits-1:0]  rad_r;
  logic [RootBits+2:0] rem_r, trial_in, trial;
  logic [RootBits-1:0] root_r;
  logic [39:0]         root_cap, shear_r;

  always_comb begin
    trial_in = {rem_r[RootBits:0], rad_r[AccBits-1 -: 2]};
    trial    = trial_in - {root_r, 2'b01};
    root_cap = root_r[RootBits-1] ? Cap40 : root_r[39:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rad_r  <= cmd.root_sel ? acc_r : sh_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rad_r <= rad_r << 2;
      if (!trial[RootBits+2]) begin
        rem_r  <= trial;
        root_r <= {root_r[RootBits-2:0], 1'b1};
      end else begin
        rem_r  <= trial_in;
        root_r <= {root_r[RootBits-2:0], 1'b0};
      end
    end
    if (cmd.shear_save) shear_r <= root_cap;
  end

  // output register
  logic [39:0] dil, rot;
  always_comb begin
    if (neg_r[4]) dil = 40'd0 - ((scaled_r[4] > Neg39) ? Neg39 : scaled_r[4]);
    else dil = (scaled_r[4] > Pos39) ? Pos39 : scaled_r[4];
    if (neg_r[5]) rot = 40'd0 - ((scaled_r[5] > Neg39) ? Neg39 : scaled_r[5]);
    else rot = (scaled_r[5] > Pos39) ? Pos39 : scaled_r[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_tdata <= miss_r ? '0 : {root_cap, shear_r, rot, dil};
      out_tuser <= miss_r;
      out_tlast <= last_r;
    end
  end

  assign sts.emit     = emit_r;
  assign sts.miss     = miss_r;
  assign sts.out_free = !out_tvalid || out_tready;

endmodule
`default_nettype wire

// ----- hdl/grid_cell_deformation.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grid_cell_deformation
// Strain figures of 2x2 grid cells from a raster stream of node displacements.
// ----------------------------------------------------------------------------
// Nodes arrive in raster order; the previous row sits in a 1024-entry line
// buffer. Once the second row has started, each node from column 1 onward
// closes a cell and yields one result (dilatation, rotation, shear, total
// distortion); other nodes yield none. A node that closes no cell passes
// through accept, line buffer read and check only; a missing cell then goes
// straight to the output handoff, after any wait for a busy output register.
// Any other node goes on through the six gain products on one 32x32
// multiplier, the four squares on one 20x20 multiplier, the two bit-serial
// square roots (setup plus 41 steps each) and the output handoff, with the
// same wait. One node is in work at a time; a finished result waits in the
// output register while the next node is accepted.
module grid_cell_deformation (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [63:0]  in_tdata,   // east_disp[31:0], north_disp[63:32]
  input  wire  [1:0]   in_tuser,   // node_missing[0], frame_start[1]
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [159:0] out_tdata,  // dilatation, rotation, shear, distortion (40 each)
  output logic         out_tuser,  // cell_missing
  output logic         out_tlast,  // row_last
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_index,
  input  wire  [31:0]  cfg_data
);
  import gcd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the step counters, issues one command set per cycle
  gcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: line buffer, arithmetic units and output register
  gcd_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grid_cell_deformation.
// ----------------------------------------------------------------------------
// Streams grid nodes into the block and predicts each closed-cell result with
// its own fixed-point strain model. Every result transfer is compared field by
// field against the oldest prediction. The run covers directed extremes,
// register corners, a column count lowered mid-row, receiver back-pressure and
// a long randomized part made of well-formed frames with some noise.
// ----------------------------------------------------------------------------
module tb;
  import gcd_pkg::*;

  localparam int NumCols = 1024;
  localparam logic [39:0] Sat40 = 40'hFF_FFFF_FFFF;
  localparam logic [39:0] PosMax = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] NegMax = 40'h80_0000_0000;

  // Term weight patterns over: left E/N, this E/N, upper-left E/N, upper E/N.
  localparam int Pattern [6][8] = '{
    '{-1, -1,  1, -1, -1,  1,  1,  1},
    '{ 1, -1,  1,  1, -1, -1, -1,  1},
    '{ 0, -1,  0,  1,  0,  1,  0, -1},
    '{-1,  0,  1,  0,  1,  0, -1,  0},
    '{-1,  1,  1,  1, -1, -1,  1, -1},
    '{-1, -1, -1,  1,  1, -1,  1,  1}
  };

  typedef struct {
    logic [39:0] dil;
    logic [39:0] rot;
    logic [39:0] shr;
    logic [39:0] dst;
    logic        miss;
    logic        last;
  } strain_t;

  typedef struct {
    longint e;
    longint n;
    bit     miss;
  } node_t;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [63:0]   in_tdata;   // east_disp[31:0], north_disp[63:32]
  logic [1:0]    in_tuser;   // node_missing[0], frame_start[1]
  logic          out_tvalid;
  logic          out_tready;
  logic [159:0]  out_tdata;  // dilatation, rotation, shear, distortion (40 each)
  logic          out_tuser;  // cell_missing
  logic          out_tlast;  // row_last
  logic          cfg_we;
  logic [1:0]    cfg_index;
  logic [31:0]   cfg_data;

  grid_cell_deformation DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: own copy of registers, line buffer and cell history.
  logic [10:0]   cols_reg;
  logic [31:0]   shear_g, twist_g, affine_g;
  longint        row_e [NumCols];
  longint        row_n [NumCols];
  bit            row_m [NumCols];
  node_t         left_nd, upleft_nd;
  int            col_pos;
  bit            below_first;

  strain_t       pending_cells[$];
  int            errors;
  int            nodes_sent;
  int            cells_checked;
  int            missing_cells;
  int            phases_run;

  // Sender burst shaping and receiver control.
  int            burst_left;
  bit            tx_steady;
  bit            rx_steady;
  bit            rx_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(30_000_000);
    $display("Verification failed");
    $finish;
  end

  task automatic report(string what, logic [39:0] got, logic [39:0] want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h (cell %0d)", what, got, want,
             cells_checked);
  endtask

  // Gain scaling of one signed sum: round-half-away magnitude, capped.
  function automatic logic [39:0] scale_term(longint s, logic [31:0] g, output bit neg);
    logic [127:0] mag;
    logic [127:0] p;
    neg = s < 0;
    mag = neg ? 128'(-s) : 128'(s);
    p = (mag * 128'(g) + 128'h8000) >> 16;
    return (p > 128'(Sat40)) ? Sat40 : p[39:0];
  endfunction

  function automatic logic [39:0] clamp_signed(logic [39:0] mag, bit neg);
    if (neg) return 40'(-(mag > NegMax ? NegMax : mag));
    return mag > PosMax ? PosMax : mag;
  endfunction

  function automatic logic [39:0] floor_root(logic [127:0] v);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 41; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return (r > 128'(Sat40)) ? Sat40 : r[39:0];
  endfunction

  // Advance the predictor by one accepted node; queue a result if a cell closes.
  task automatic predict_node(logic [31:0] e, logic [31:0] n, bit miss, bit fs);
    int          cols;
    int          col;
    bit          last;
    node_t       cur, up;
    strain_t     res;
    longint      v[8];
    longint      s;
    logic [39:0] mag[6];
    bit          neg[6];
    logic [31:0] g;
    logic [127:0] sq_sh, sq_all;
    cols = int'(cols_reg);
    if (cols < 2) cols = 2;
    if (cols > NumCols) cols = NumCols;
    cur.e = longint'(signed'(e));
    cur.n = longint'(signed'(n));
    cur.miss = miss;
    if (fs) begin
      col_pos = 0;
      below_first = 0;
    end
    col = (col_pos >= NumCols) ? NumCols - 1 : col_pos;
    last = col >= cols - 1;
    up.e = row_e[col];
    up.n = row_n[col];
    up.miss = row_m[col];
    if (below_first && col >= 1) begin
      res = '{default: '0};
      res.last = last;
      if (left_nd.miss || cur.miss || upleft_nd.miss || up.miss) begin
        res.miss = 1'b1;
      end else begin
        v = '{left_nd.e, left_nd.n, cur.e, cur.n, upleft_nd.e, upleft_nd.n, up.e, up.n};
        for (int t = 0; t < 6; t++) begin
          s = 0;
          for (int j = 0; j < 8; j++) s += longint'(Pattern[t][j]) * v[j];
          g = (t < 2) ? shear_g : (t < 4 ? twist_g : affine_g);
          mag[t] = scale_term(s, g, neg[t]);
        end
        res.dil = clamp_signed(mag[4], neg[4]);
        res.rot = clamp_signed(mag[5], neg[5]);
        sq_sh = 128'(mag[0]) * 128'(mag[0]) + 128'(mag[1]) * 128'(mag[1]);
        sq_all = sq_sh + 128'(mag[2]) * 128'(mag[2]) + 128'(mag[3]) * 128'(mag[3]);
        res.shr = floor_root(sq_sh);
        res.dst = floor_root(sq_all);
      end
      pending_cells.push_back(res);
    end
    upleft_nd = up;
    row_e[col] = cur.e;
    row_n[col] = cur.n;
    row_m[col] = cur.miss;
    left_nd = cur;
    if (last) begin
      col_pos = 0;
      below_first = 1;
    end else begin
      col_pos = col + 1;
    end
  endtask

  // Present one node; hold until the transfer, then maybe open a gap.
  task automatic send_node(logic [31:0] e, logic [31:0] n, bit miss, bit fs);
    in_tvalid <= 1'b1;
    in_tdata  <= {n, e};
    in_tuser  <= {fs, miss};
    do @(posedge clk); while (!in_tready);
    predict_node(e, n, miss, fs);
    nodes_sent++;
    if (!tx_steady) begin
      if (burst_left == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(0, 15);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop valid, wait until every predicted cell has come, then let a node
  // that closes no cell finish.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // Write all four registers back to back; only while the block is idle.
  task automatic set_config(logic [10:0] cols, logic [31:0] sg, logic [31:0] tg,
                            logic [31:0] ag);
    logic [31:0] vals[4];
    vals = '{32'(cols), sg, tg, ag};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cols_reg = cols;
    shear_g  = sg;
    twist_g  = tg;
    affine_g = ag;
  endtask

  function automatic logic [31:0] pick_disp();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'($urandom_range(0, 511)) - 32'd256;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0001_0000;
      3:       return 32'($urandom_range(1, 4095));
      default: return $urandom;
    endcase
  endfunction

  // One grid of random content; noise adds stray frame starts.
  task automatic send_grid(int cols, int rows, bit noise);
    bit fs;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        fs = (r == 0 && c == 0) || (noise && $urandom_range(0, 99) == 0);
        send_node(pick_disp(), pick_disp(), $urandom_range(0, 99) < 8, fs);
      end
    end
  endtask

  // Result checker: compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    strain_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cells.size() == 0) begin
        report("unexpected result", out_tdata[39:0], 40'd0);
      end else begin
        want = pending_cells.pop_front();
        if (out_tdata[39:0]    !== want.dil) report("dilatation", out_tdata[39:0], want.dil);
        if (out_tdata[79:40]   !== want.rot) report("rotation", out_tdata[79:40], want.rot);
        if (out_tdata[119:80]  !== want.shr) report("shear", out_tdata[119:80], want.shr);
        if (out_tdata[159:120] !== want.dst) report("distortion", out_tdata[159:120], want.dst);
        if (out_tuser !== want.miss) report("cell_missing", 40'(out_tuser), 40'(want.miss));
        if (out_tlast !== want.last) report("row_last", 40'(out_tlast), 40'(want.last));
        if (want.miss) missing_cells++;
        cells_checked++;
      end
    end
  end

  // Receiver: its own stall rhythm, quiet stretches, and long hold-offs on request.
  initial begin
    int phase;
    phase = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (600) @(posedge clk);
        rx_hold_req = 0;
      end else if (rx_steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= (phase % 13 >= 5) || ($urandom_range(0, 2) == 0);
      end
    end
  end

  // Directed: start without frame start, field extremes, missing corners, row ends.
  task automatic test_directed();
    set_config(11'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // first row arrives with no frame start after reset
    send_node(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send_node(32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    send_node(32'h8000_0000, 32'h8000_0000, 0, 0);
    send_node(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send_node(32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send_node(32'h0, 32'h0, 0, 0);
    send_node(32'hFFFF_FFFF, 32'h0000_0001, 0, 0);
    send_node(32'h0, 32'h0, 1, 0);           // missing corner
    drain();
    set_config(11'd2, 32'h0001_0000, 32'h0000_8000, 32'h0000_0001);
    send_node(32'h0000_0010, 32'hFFFF_FFF0, 0, 1);
    send_node(32'h0000_0003, 32'h0000_0005, 1, 0);
    send_node(32'h0000_0001, 32'h0000_0002, 0, 0);
    send_node(32'hFFFF_FFFD, 32'h0000_0007, 0, 0);
    send_node(32'h5555_5555, 32'hAAAA_AAAA, 0, 0);
    send_node(32'hAAAA_AAAA, 32'h5555_5555, 0, 0);
    drain();
  endtask

  // Register corners: counts below 2 and above the buffer, zero and full gains.
  task automatic test_register_corners();
    set_config(11'd0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_grid(2, 3, 0);
    drain();
    set_config(11'd1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_grid(2, 3, 0);
    drain();
    // one full-width row, then the start of the next so that cells close
    set_config(11'h7FF, $urandom, $urandom, $urandom);
    send_grid(NumCols, 1, 0);
    for (int c = 0; c < 6; c++) send_node(pick_disp(), pick_disp(), 0, 0);
    drain();
    phases_run += 3;
  endtask

  // Lower the column count while a row is half done: the row ends at once.
  task automatic test_lowered_row();
    set_config(11'd8, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_grid(8, 1, 0);
    for (int c = 0; c < 5; c++) send_node(pick_disp(), pick_disp(), 0, 0);
    drain();
    set_config(11'd3, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    for (int c = 0; c < 10; c++) send_node(pick_disp(), pick_disp(), 0, 0);
    drain();
    phases_run++;
  endtask

  // Hold the receiver off while nodes keep coming so the input stalls.
  task automatic test_backpressure();
    set_config(11'd4, pick_gain(), pick_gain(), pick_gain());
    tx_steady = 1;
    rx_hold_req = 1;
    send_grid(4, 10, 0);
    tx_steady = 0;
    drain();
    phases_run++;
  endtask

  // Random grids, mostly narrow, with changing gains and idle patterns.
  task automatic test_random(int budget);
    int start;
    int cols;
    start = nodes_sent;
    while (nodes_sent - start < budget) begin
      cols = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
      tx_steady = $urandom_range(0, 3) == 0;
      rx_steady = $urandom_range(0, 3) == 0;
      set_config(11'(cols), pick_gain(), pick_gain(), pick_gain());
      send_grid(cols, $urandom_range(2, 6), $urandom_range(0, 3) == 0);
      drain();
      phases_run++;
    end
    tx_steady = 0;
    rx_steady = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = RegColumns;
    cfg_data = '0;
    errors = 0;
    nodes_sent = 0;
    cells_checked = 0;
    missing_cells = 0;
    phases_run = 0;
    burst_left = 0;
    tx_steady = 0;
    rx_steady = 0;
    rx_hold_req = 0;
    cols_reg = 11'd1024;
    shear_g = 32'h0001_0000;
    twist_g = 32'h0001_0000;
    affine_g = 32'h0001_0000;
    foreach (row_e[i]) begin
      row_e[i] = 0;
      row_n[i] = 0;
      row_m[i] = 0;
    end
    left_nd = '{0, 0, 0};
    upleft_nd = '{0, 0, 0};
    col_pos = 0;
    below_first = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_corners();
    test_lowered_row();
    test_backpressure();
    test_random(180);

    drain();
    $display("Sent %0d nodes over %0d configured phases; checked %0d cells (%0d missing).",
             nodes_sent, phases_run, cells_checked, missing_cells);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/gcd_pkg.sv
hdl/gcd_ctrl.sv
hdl/gcd_dpath.sv
hdl/grid_cell_deformation.sv
tb/tb.sv
